// File: sv/u8d_pkg.sv
// Package for the strict UTF-8 decoder: constants, the job record that
// travels between the front and back parts, and sizing defaults.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package u8d_pkg;

    // Default depth of the job queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    // Code point limits and the raw-byte sentinel base.
    localparam logic [20:0] SENT_BASE = 21'h110000;
    localparam logic [20:0] SURR_LO   = 21'h00D800;
    localparam logic [20:0] SURR_HI   = 21'h00DFFF;
    localparam logic [20:0] CP_MAX    = 21'h10FFFF;
    localparam logic [20:0] MIN_LEN2  = 21'h000080;
    localparam logic [20:0] MIN_LEN3  = 21'h000800;
    localparam logic [20:0] MIN_LEN4  = 21'h010000;

    // One job holds every result that a single input word causes: first
    // pre_cnt held bytes flushed as sentinels, then an optional tail result.
    typedef struct packed {
        logic [2:0][7:0] held;
        logic [1:0]      pre_cnt;
        logic            tail_vld;
        logic            tail_raw;
        logic [20:0]     tail_val;
    } t_job;

    // Sentinel code for a raw byte.
    function automatic logic [20:0] raw_code(input logic [7:0] b);
        return SENT_BASE | {13'd0, b};
    endfunction

endpackage

`default_nettype wire

// File: sv/u8d_ifs.sv
// Stream channel interfaces of the strict UTF-8 decoder: the byte input
// channel and the code point output channel. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface u8d_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       end_of_text;

    modport source (output valid, byte_in, end_of_text, input ready);
    modport sink   (input valid, byte_in, end_of_text, output ready);
endinterface

interface u8d_out_if;
    logic        valid;
    logic        ready;
    logic [20:0] code_value;
    logic        raw_byte;
    logic        run_last;

    modport source (output valid, code_value, raw_byte, run_last, input ready);
    modport sink   (input valid, code_value, raw_byte, run_last, output ready);
endinterface

`default_nettype wire

// File: sv/u8d_front.sv
// Front part of the strict UTF-8 decoder: accepts bytes, tracks the open
// sequence and turns each byte into at most one job. Depends on u8d_pkg, u8d_ifs.
`timescale 1ns / 1ps
`default_nettype none

module u8d_front import u8d_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    u8d_in_if.sink i_in,
    input  logic   i_q_full,
    output logic   o_push,
    output t_job   o_job
);

    logic [7:0]  r_held [3];
    logic [7:0]  n_held [3];
    logic [1:0]  r_held_cnt, n_held_cnt;
    logic [2:0]  r_seq_len, n_seq_len;
    logic [20:0] r_partial, n_partial;

    logic [7:0]  w_byte;
    logic        w_eot;
    logic        w_accept;
    logic        w_cont;
    logic        w_open;
    logic [20:0] w_v;
    logic        w_complete;
    logic        w_bad;
    logic        w_lead_ok;
    logic [2:0]  w_lead_len;
    logic [20:0] w_lead_bits;
    t_job        w_job;

    assign w_byte     = i_in.byte_in;
    assign w_eot      = i_in.end_of_text;
    assign i_in.ready = !i_q_full;
    assign w_accept   = i_in.valid && !i_q_full;

    // Continuation check and the value with this byte appended.
    assign w_cont     = (w_byte[7:6] == 2'b10);
    assign w_open     = (r_seq_len != 3'd0);
    assign w_v        = {r_partial[14:0], w_byte[5:0]};
    assign w_complete = (({1'b0, r_held_cnt} + 3'd1) >= r_seq_len);

    // Overlong, surrogate and range checks on a completed sequence.
    always_comb begin
        w_bad = 1'b0;
        if (r_seq_len == 3'd2 && w_v < MIN_LEN2) w_bad = 1'b1;
        if (r_seq_len == 3'd3 && w_v < MIN_LEN3) w_bad = 1'b1;
        if (r_seq_len == 3'd4 && w_v < MIN_LEN4) w_bad = 1'b1;
        if (w_v >= SURR_LO && w_v <= SURR_HI) w_bad = 1'b1;
        if (w_v > CP_MAX) w_bad = 1'b1;
    end

    // Lead byte classification.
    always_comb begin
        w_lead_ok   = 1'b1;
        w_lead_len  = 3'd0;
        w_lead_bits = 21'd0;
        if (w_byte[7:5] == 3'b110) begin
            w_lead_len  = 3'd2;
            w_lead_bits = {16'd0, w_byte[4:0]};
        end else if (w_byte[7:4] == 4'b1110) begin
            w_lead_len  = 3'd3;
            w_lead_bits = {17'd0, w_byte[3:0]};
        end else if (w_byte[7:3] == 5'b11110) begin
            w_lead_len  = 3'd4;
            w_lead_bits = {18'd0, w_byte[2:0]};
        end else begin
            w_lead_ok = 1'b0;
        end
    end

    // Next state and the job for this word.
    always_comb begin
        n_held     = r_held;
        n_held_cnt = r_held_cnt;
        n_seq_len  = r_seq_len;
        n_partial  = r_partial;
        for (int k = 0; k < 3; k++) begin
            w_job.held[k] = r_held[k];
        end
        w_job.pre_cnt  = 2'd0;
        w_job.tail_vld = 1'b0;
        w_job.tail_raw = 1'b0;
        w_job.tail_val = 21'd0;

        if (w_open && w_cont) begin
            if (w_complete) begin
                w_job.tail_vld = 1'b1;
                if (w_bad) begin
                    w_job.pre_cnt  = r_held_cnt;
                    w_job.tail_raw = 1'b1;
                    w_job.tail_val = raw_code(w_byte);
                end else begin
                    w_job.tail_val = w_v;
                end
                n_held_cnt = 2'd0;
                n_seq_len  = 3'd0;
                n_partial  = 21'd0;
            end else if (w_eot) begin
                // Truncated at end of text: everything held plus this byte.
                w_job.pre_cnt  = r_held_cnt;
                w_job.tail_vld = 1'b1;
                w_job.tail_raw = 1'b1;
                w_job.tail_val = raw_code(w_byte);
                n_held_cnt     = 2'd0;
                n_seq_len      = 3'd0;
                n_partial      = 21'd0;
            end else begin
                for (int k = 0; k < 3; k++) begin
                    if (2'(k) == r_held_cnt) n_held[k] = w_byte;
                end
                n_held_cnt = r_held_cnt + 2'd1;
                n_partial  = w_v;
            end
        end else begin
            // A breaking byte flushes what is held, then acts as a lead.
            if (w_open) begin
                w_job.pre_cnt = r_held_cnt;
                n_held_cnt    = 2'd0;
                n_seq_len     = 3'd0;
                n_partial     = 21'd0;
            end
            if (!w_byte[7]) begin
                w_job.tail_vld = 1'b1;
                w_job.tail_val = {13'd0, w_byte};
            end else if (w_lead_ok && !w_eot) begin
                n_held[0]  = w_byte;
                n_held_cnt = 2'd1;
                n_seq_len  = w_lead_len;
                n_partial  = w_lead_bits;
            end else begin
                w_job.tail_vld = 1'b1;
                w_job.tail_raw = 1'b1;
                w_job.tail_val = raw_code(w_byte);
            end
        end
    end

    assign o_job  = w_job;
    assign o_push = w_accept && (w_job.tail_vld || (w_job.pre_cnt != 2'd0));

    // Sequence control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_cnt <= 2'd0;
            r_seq_len  <= 3'd0;
            r_partial  <= 21'd0;
        end else if (w_accept) begin
            r_held_cnt <= n_held_cnt;
            r_seq_len  <= n_seq_len;
            r_partial  <= n_partial;
        end
    end

    // Held bytes carry no reset; only entries below the count are used.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_held <= n_held;
        end
    end

    // An open sequence always holds its lead and is never already complete.
    a_open_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seq_len != 3'd0 |-> (r_held_cnt != 2'd0 && {1'b0, r_held_cnt} < r_seq_len))
        else $error("open sequence with an impossible held count");

    // With no sequence open nothing is held or gathered.
    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seq_len == 3'd0 |-> (r_held_cnt == 2'd0 && r_partial == 21'd0))
        else $error("state left over with no open sequence");

endmodule

`default_nettype wire

// File: sv/u8d_queue.sv
// Job queue between the front and back parts of the strict UTF-8 decoder.
// Depends on u8d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u8d_queue import u8d_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_head,
    output logic o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          w_wr, w_rd;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            if (w_rd) r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            if (w_wr && !w_rd) r_cnt <= r_cnt + CW'(1);
            else if (w_rd && !w_wr) r_cnt <= r_cnt - CW'(1);
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wr] <= i_job;
    end

    // The back part only pops a job that is there.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from an empty job queue");

endmodule

`default_nettype wire

// File: sv/u8d_back.sv
// Back part of the strict UTF-8 decoder: expands the job at the queue head
// into one result word per cycle while the output is not stalled, through an
// output register. Depends on u8d_pkg, u8d_ifs.
`timescale 1ns / 1ps
`default_nettype none

module u8d_back import u8d_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_job       i_head,
    input  logic       i_q_empty,
    output logic       o_pop,
    u8d_out_if.source  o_out
);

    logic [1:0]  r_idx;
    logic        r_vld;
    logic [20:0] r_code;
    logic        r_raw;
    logic        r_last;

    logic [2:0]  w_total;
    logic        w_last;
    logic        w_load;
    logic        w_in_pre;
    logic [20:0] w_code;
    logic        w_raw;

    // Position of the current result within the head job.
    assign w_total  = {1'b0, i_head.pre_cnt} + {2'd0, i_head.tail_vld};
    assign w_last   = (({1'b0, r_idx} + 3'd1) == w_total);
    assign w_in_pre = (r_idx < i_head.pre_cnt);
    assign w_load   = !i_q_empty && (!r_vld || o_out.ready);
    assign o_pop    = w_load && w_last;

    // Select a flushed byte or the tail result.
    always_comb begin
        if (w_in_pre) begin
            w_code = raw_code(i_head.held[r_idx]);
            w_raw  = 1'b1;
        end else begin
            w_code = i_head.tail_val;
            w_raw  = i_head.tail_raw;
        end
    end

    // Control: result index and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
            r_vld <= 1'b0;
        end else begin
            if (w_load) begin
                r_idx <= w_last ? 2'd0 : r_idx + 2'd1;
                r_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_vld <= 1'b0;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_code <= w_code;
            r_raw  <= w_raw;
            r_last <= w_last;
        end
    end

    assign o_out.valid      = r_vld;
    assign o_out.code_value = r_code;
    assign o_out.raw_byte   = r_raw;
    assign o_out.run_last   = r_last;

    // A job partly sent stays at the queue head until its last result.
    a_job_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx != 2'd0 |-> !i_q_empty)
        else $error("job left the queue before its last result");

endmodule

`default_nettype wire

// File: sv/utf8_strict_decoder_top.sv
// Top level of the strict UTF-8 decoder: front part, job queue, back part.
// Depends on u8d_pkg, u8d_ifs, u8d_front, u8d_queue, u8d_back.
//
// Usage: bytes enter on i_in (byte_in, end_of_text) with a valid/ready
// handshake; code points leave on o_out (code_value, raw_byte, run_last).
// Each byte causes zero to four result words; run_last marks the final one
// a byte causes. Malformed input gives sentinels 0x110000 plus the raw byte.
// With the queue empty and the output register free, the first result of a
// byte passes through the job queue and then the output register on its way
// to o_out. A byte that is only held gives no result.
// Throughput: one byte per cycle while the queue has room; one result word
// per cycle while the receiver is ready. A byte with k results holds the
// back part until all k have left the single output register.
// The front keeps taking bytes while the queue has room (depth Q_DEPTH), so
// input and output stall independently. When the receiver stalls, the
// output word holds, the queue fills, and then i_in.ready drops.
// Reset (synchronous, i_rst_n low) closes any open sequence, empties the
// queue and drops o_out.valid; held bytes need no clearing.
`timescale 1ns / 1ps
`default_nettype none

module utf8_strict_decoder_top import u8d_pkg::*; #(
    parameter int Q_DEPTH = QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    u8d_in_if.sink     i_in,
    u8d_out_if.source  o_out
);

    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;
    t_job w_job;
    t_job w_head;

    // Byte intake and classification.
    u8d_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_job    (w_job)
    );

    // Decoupling queue.
    u8d_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty)
    );

    // Result expansion and output register.
    u8d_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (w_head),
        .i_q_empty (w_empty),
        .o_pop     (w_pop),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire

// File: bench/tb_utf8_strict_decoder_top.sv
// Self-checking testbench for utf8_strict_decoder_top: byte words go in through a
// queue-fed driver, and a clocked monitor compares every code point word against a
// built-in strict UTF-8 decoder. Depends on u8d_pkg, u8d_ifs and the decoder RTL.
`timescale 1ns / 1ps

module tb_utf8_strict_decoder_top;
    import u8d_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_BYTES = 250;
    localparam int STEADY_TAIL = 40;
    localparam int MAX_SHOWN = 10;

    typedef struct {
        logic [7:0] b;
        logic       eot;
        logic       drain;
    } t_byte_item;

    typedef struct {
        logic [20:0] code;
        logic        raw;
        logic        last;
    } t_code_word;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    u8d_in_if  in_if();
    u8d_out_if out_if();

    utf8_strict_decoder_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #6 i_clk = ~i_clk;

    t_byte_item byte_queue[$];
    t_code_word expected_codes[$];
    t_code_word step_codes[$];
    int         mismatches = 0;
    int         cycles = 0;
    logic       byte_taken = 1'b0;
    int         tx_idle = 0, tx_run = 0, rx_idle = 0, rx_run = 0;

    // Decoder state mirrored for prediction.
    logic [7:0]  held_seq[3] = '{8'h00, 8'h00, 8'h00};
    int          held_cnt = 0;
    int          open_len = 0;
    logic [20:0] gathered = '0;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    task automatic emit_code(input logic [20:0] code, input logic raw);
        t_code_word w;
        w.code = code;
        w.raw  = raw;
        w.last = 1'b0;
        step_codes = {step_codes, w};
    endtask

    task automatic emit_sentinel(input logic [7:0] b);
        emit_code(SENT_BASE + {13'd0, b}, 1'b1);
    endtask

    task automatic close_sequence();
        held_cnt = 0;
        open_len = 0;
        gathered = '0;
    endtask

    task automatic flush_sequence();
        for (int k = 0; k < held_cnt && k < 3; k++) emit_sentinel(held_seq[k]);
        close_sequence();
    endtask

    // Classify a byte seen where a new code point starts.
    task automatic start_code(input logic [7:0] b, input logic eot);
        int          len;
        logic [20:0] bits;
        if (b < 8'h80) begin
            emit_code({13'd0, b}, 1'b0);
            return;
        end
        if ((b & 8'hE0) == 8'hC0) begin
            len = 2;
            bits = {16'd0, b[4:0]};
        end else if ((b & 8'hF0) == 8'hE0) begin
            len = 3;
            bits = {17'd0, b[3:0]};
        end else if ((b & 8'hF8) == 8'hF0) begin
            len = 4;
            bits = {18'd0, b[2:0]};
        end else begin
            emit_sentinel(b);
            return;
        end
        if (eot) begin
            emit_sentinel(b);
            return;
        end
        held_seq[0] = b;
        held_cnt = 1;
        open_len = len;
        gathered = bits;
    endtask

    // Work out every code point word caused by one accepted byte word.
    task automatic decode_byte(input logic [7:0] b, input logic eot);
        logic [20:0] v;
        logic        bad;
        t_code_word  w;
        step_codes.delete();
        if (open_len != 0) begin
            if ((b & 8'hC0) == 8'h80) begin
                v = {gathered[14:0], b[5:0]};
                if (held_cnt + 1 >= open_len) begin
                    bad = (open_len == 2 && v < MIN_LEN2) || (open_len == 3 && v < MIN_LEN3)
                        || (open_len == 4 && v < MIN_LEN4)
                        || (v >= SURR_LO && v <= SURR_HI) || v > CP_MAX;
                    if (bad) begin
                        flush_sequence();
                        emit_sentinel(b);
                    end else begin
                        emit_code(v, 1'b0);
                        close_sequence();
                    end
                end else begin
                    held_seq[held_cnt] = b;
                    held_cnt = held_cnt + 1;
                    gathered = v;
                    if (eot) flush_sequence();
                end
            end else begin
                // A byte that breaks the open sequence starts over as a lead.
                flush_sequence();
                start_code(b, eot);
            end
        end else begin
            start_code(b, eot);
        end
        for (int k = 0; k < step_codes.size(); k++) begin
            w = step_codes[k];
            w.last = (k == step_codes.size() - 1);
            expected_codes = {expected_codes, w};
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------

    task automatic add_byte(input logic [7:0] b, input logic eot, input logic drain);
        t_byte_item it;
        it.b = b;
        it.eot = eot;
        it.drain = drain;
        byte_queue = {byte_queue, it};
    endtask

    function automatic logic [7:0] any_cont();
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    // Random well-formed encoding of 1 to 4 bytes.
    task automatic make_valid(output logic [7:0] seq[$]);
        logic [20:0] cp;
        int          len;
        len = $urandom_range(1, 4);
        case (len)
            1: begin
                cp = 21'($urandom_range(0, 'h7F));
                seq = '{cp[7:0]};
            end
            2: begin
                cp = 21'($urandom_range('h80, 'h7FF));
                seq = '{{3'b110, cp[10:6]}, {2'b10, cp[5:0]}};
            end
            3: begin
                do cp = 21'($urandom_range('h800, 'hFFFF));
                while (cp >= SURR_LO && cp <= SURR_HI);
                seq = '{{4'b1110, cp[15:12]}, {2'b10, cp[11:6]}, {2'b10, cp[5:0]}};
            end
            default: begin
                cp = 21'($urandom_range('h10000, 'h10FFFF));
                seq = '{{5'b11110, cp[20:18]}, {2'b10, cp[17:12]},
                        {2'b10, cp[11:6]}, {2'b10, cp[5:0]}};
            end
        endcase
    endtask

    // Complete sequences that are overlong, surrogate or above the code range.
    task automatic make_rejected(output logic [7:0] seq[$]);
        case ($urandom_range(0, 5))
            0: seq = '{8'hC0 | 8'($urandom_range(0, 1)), any_cont()};
            1: seq = '{8'hE0, 8'($urandom_range('h80, 'h9F)), any_cont()};
            2: seq = '{8'hED, 8'($urandom_range('hA0, 'hBF)), any_cont()};
            3: seq = '{8'hF0, 8'($urandom_range('h80, 'h8F)), any_cont(), any_cont()};
            4: seq = '{8'hF4, 8'($urandom_range('h90, 'hBF)), any_cont(), any_cont()};
            default: seq = '{8'($urandom_range('hF5, 'hF7)), any_cont(), any_cont(),
                             any_cont()};
        endcase
    endtask

    task automatic fill_random();
        logic [7:0] seq[$];
        int         added;
        int         pick;
        logic       eot_tail;
        added = 0;
        while (added < RANDOM_BYTES) begin
            pick = $urandom_range(0, 99);
            eot_tail = ($urandom_range(0, 11) == 0);
            if (pick < 55) begin
                make_valid(seq);
            end else if (pick < 67) begin
                make_rejected(seq);
            end else if (pick < 80) begin
                // Truncated sequence: what comes next breaks it unless it is a continuation.
                do make_valid(seq); while (seq.size() < 2);
                seq = seq[0:$urandom_range(0, seq.size() - 2)];
            end else if (pick < 90) begin
                seq = '{8'($urandom_range(0, 255))};
            end else begin
                do make_valid(seq); while (seq.size() < 2);
                seq = seq[0:$urandom_range(0, seq.size() - 1)];
                eot_tail = 1'b1;
            end
            foreach (seq[k]) begin
                // The first random word waits until the decoder has fully drained.
                add_byte(seq[k], eot_tail && (k == seq.size() - 1), added == 0);
                added++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Handshake pacing
    // ------------------------------------------------------------------

    task automatic pace(inout int idle_left, inout int run_left, output logic active);
        if (byte_queue.size() < STEADY_TAIL) begin
            active = 1'b1;
        end else if (idle_left > 0) begin
            idle_left--;
            active = 1'b0;
        end else if (run_left > 0) begin
            run_left--;
            active = 1'b1;
        end else begin
            if ($urandom_range(0, 2) == 0) idle_left = $urandom_range(1, 14);
            else run_left = $urandom_range(1, 40);
            active = 1'b1;
        end
    endtask

    // Driver: present the head of the byte queue, holding it until accepted.
    always @(negedge i_clk) begin
        logic hold;
        logic go;
        hold = in_if.valid && !byte_taken;
        byte_taken = 1'b0;
        if (!i_rst_n) begin
            go = 1'b0;
        end else if (hold) begin
            go = 1'b1;
        end else if (byte_queue.size() == 0) begin
            go = 1'b0;
        end else if (byte_queue[0].drain && (expected_codes.size() != 0 || out_if.valid)) begin
            go = 1'b0;
        end else begin
            pace(tx_idle, tx_run, go);
        end
        if (go) begin
            in_if.valid       <= 1'b1;
            in_if.byte_in     <= byte_queue[0].b;
            in_if.end_of_text <= byte_queue[0].eot;
        end else begin
            in_if.valid       <= 1'b0;
            in_if.byte_in     <= 8'($urandom);
            in_if.end_of_text <= 1'($urandom);
        end
    end

    // Receiver side stalls in bursts.
    always @(negedge i_clk) begin
        logic take;
        if (!i_rst_n) take = 1'b0;
        else pace(rx_idle, rx_run, take);
        out_if.ready <= take;
    end

    // Monitor: predict on each accepted byte word, check each accepted result word.
    always @(posedge i_clk) begin
        t_code_word want;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                decode_byte(in_if.byte_in, in_if.end_of_text);
                void'(byte_queue.pop_front());
                byte_taken = 1'b1;
            end
            if (out_if.valid && out_if.ready) begin
                if (expected_codes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("unexpected word: code=%h raw=%b last=%b",
                                 out_if.code_value, out_if.raw_byte, out_if.run_last);
                end else begin
                    want = expected_codes.pop_front();
                    if (out_if.code_value !== want.code || out_if.raw_byte !== want.raw
                            || out_if.run_last !== want.last) begin
                        mismatches++;
                        if (mismatches <= MAX_SHOWN)
                            $display({"mismatch: expected code=%h raw=%b last=%b,",
                                      " got code=%h raw=%b last=%b"},
                                     want.code, want.raw, want.last,
                                     out_if.code_value, out_if.raw_byte, out_if.run_last);
                    end
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial begin
        in_if.valid       = 1'b0;
        in_if.byte_in     = 8'h00;
        in_if.end_of_text = 1'b0;
        out_if.ready      = 1'b0;

        // Directed words: range ends, each rejection kind, breaks and end of text.
        add_byte(8'h00, 1'b0, 1'b0);
        add_byte(8'h7F, 1'b0, 1'b0);
        add_byte(8'hC2, 1'b0, 1'b0);
        add_byte(8'h80, 1'b0, 1'b0);
        add_byte(8'hF4, 1'b0, 1'b0);
        add_byte(8'h8F, 1'b0, 1'b0);
        add_byte(8'hBF, 1'b0, 1'b0);
        add_byte(8'hBF, 1'b0, 1'b0);
        // Stray continuation and a lead that can never be valid.
        add_byte(8'h80, 1'b0, 1'b0);
        add_byte(8'hFF, 1'b0, 1'b0);
        // Overlong two-byte form.
        add_byte(8'hC0, 1'b0, 1'b0);
        add_byte(8'h80, 1'b0, 1'b0);
        // Surrogate.
        add_byte(8'hED, 1'b0, 1'b0);
        add_byte(8'hA0, 1'b0, 1'b0);
        add_byte(8'h80, 1'b0, 1'b0);
        // Above the code range: four sentinels from one word.
        add_byte(8'hF5, 1'b0, 1'b0);
        add_byte(8'h80, 1'b0, 1'b0);
        add_byte(8'h80, 1'b0, 1'b0);
        add_byte(8'h80, 1'b0, 1'b0);
        // Breaking byte re-read as ASCII.
        add_byte(8'hE2, 1'b0, 1'b0);
        add_byte(8'h41, 1'b0, 1'b0);
        // End of text on a lead, mid-sequence, and on a completing byte.
        add_byte(8'hC3, 1'b1, 1'b0);
        add_byte(8'hE2, 1'b0, 1'b0);
        add_byte(8'h82, 1'b1, 1'b0);
        add_byte(8'hC3, 1'b0, 1'b0);
        add_byte(8'hA9, 1'b1, 1'b0);

        fill_random();

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (byte_queue.size() != 0) @(posedge i_clk);
        while (expected_codes.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (mismatches == 0 && expected_codes.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/u8d_pkg.sv
sv/u8d_ifs.sv
sv/u8d_front.sv
sv/u8d_queue.sv
sv/u8d_back.sv
sv/utf8_strict_decoder_top.sv
bench/tb_utf8_strict_decoder_top.sv
